>>> rtl/core/mtf_pkg.sv
// shared constants and control types for the move-to-front codec
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

    localparam int SYM_W                 = 8;
    localparam int ALPHABET_SIZE_DEFAULT = 256;
    localparam int GROUP_SIZE            = 16;
    localparam int GRP_IDX_W             = 4;

    typedef struct packed {
        logic load;        // input transfer, latch item
        logic scan_group;  // register per-group compare results
        logic scan_final;  // merge groups into hit, position, symbol
        logic move;        // rotate list and write result
    } mtf_ctl_t;

    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
    } mtf_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mtf_datapath.sv
// symbol list cells, two-level search tree, output register
// depends on mtf_pkg; driven by mtf_controller
`timescale 1ns / 1ps
`default_nettype none

module mtf_datapath #(
    parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_data,
    input  wire logic [mtf_pkg::SYM_W-1:0] in_byte,
    input  wire logic                     block_start,
    input  wire logic                     out_stall,
    input  wire mtf_pkg::mtf_ctl_t        ctl,
    output mtf_pkg::mtf_stat_t            stat,
    output logic                          out_valid,
    output logic [mtf_pkg::SYM_W-1:0]     out_byte
);

    localparam int SW         = mtf_pkg::SYM_W;
    localparam int GS         = mtf_pkg::GROUP_SIZE;
    localparam int NUM_GROUPS = (ALPHABET_SIZE + GS - 1) / GS;
    localparam int PAD_SIZE   = NUM_GROUPS * GS;

    logic [SW-1:0] cell_reg [ALPHABET_SIZE];
    logic          direction_reg;
    logic [SW-1:0] byte_reg;

    logic [SW-1:0]          rank;
    logic [PAD_SIZE-1:0]    match;
    logic [SW-1:0]          cell_pad [PAD_SIZE];

    logic [NUM_GROUPS-1:0]  grp_hit_next, grp_hit_reg;
    logic [mtf_pkg::GRP_IDX_W-1:0] grp_low_next [NUM_GROUPS];
    logic [mtf_pkg::GRP_IDX_W-1:0] grp_low_reg  [NUM_GROUPS];
    logic [SW-1:0]          grp_sym_next [NUM_GROUPS];
    logic [SW-1:0]          grp_sym_reg  [NUM_GROUPS];

    logic          hit_next, hit_reg;
    logic [SW-1:0] pos_next, pos_reg;
    logic [SW-1:0] sym_next, sym_reg;

    logic          out_valid_reg;
    logic [SW-1:0] out_byte_reg;

    // saturated rank for decode
    assign rank = ({1'b0, byte_reg} >= (SW+1)'(ALPHABET_SIZE))
                ? SW'(ALPHABET_SIZE - 1) : byte_reg;

    for (genvar i = 0; i < PAD_SIZE; i++)
    begin : g_cmp
        if (i < ALPHABET_SIZE)
        begin : g_live
            assign cell_pad[i] = cell_reg[i];
            assign match[i]    = direction_reg ? (SW'(i) == rank)
                                               : (cell_reg[i] == byte_reg);
        end
        else
        begin : g_pad
            assign cell_pad[i] = '0;
            assign match[i]    = 1'b0;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_hit_next[g] = 1'b0;
            grp_low_next[g] = '0;
            grp_sym_next[g] = '0;
            for (int k = 0; k < GS; k++)
            begin
                if (match[g*GS + k])
                begin
                    grp_hit_next[g] = 1'b1;
                    grp_low_next[g] = grp_low_next[g] | mtf_pkg::GRP_IDX_W'(k);
                    grp_sym_next[g] = grp_sym_next[g] | cell_pad[g*GS + k];
                end
            end
        end
    end

    always_comb
    begin
        hit_next = 1'b0;
        pos_next = '0;
        sym_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (grp_hit_reg[g])
            begin
                hit_next = 1'b1;
                pos_next = pos_next | SW'(g * GS) | SW'(grp_low_reg[g]);
                sym_next = sym_next | grp_sym_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            byte_reg <= in_byte;
        end
        if (ctl.scan_group)
        begin
            grp_hit_reg <= grp_hit_next;
            grp_low_reg <= grp_low_next;
            grp_sym_reg <= grp_sym_next;
        end
        if (ctl.scan_final)
        begin
            hit_reg <= hit_next;
            pos_reg <= pos_next;
            sym_reg <= sym_next;
        end
        if (ctl.move)
        begin
            out_byte_reg <= direction_reg ? sym_reg
                          : (hit_reg ? pos_reg : SW'(ALPHABET_SIZE - 1));
        end
    end

    // list cells, identity at reset and at block start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                cell_reg[i] <= SW'(i);
            end
        end
        else if (ctl.load && block_start)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                cell_reg[i] <= SW'(i);
            end
        end
        else if (ctl.move && hit_reg)
        begin
            cell_reg[0] <= sym_reg;
            for (int i = 1; i < ALPHABET_SIZE; i++)
            begin
                if (SW'(i) <= pos_reg)
                begin
                    cell_reg[i] <= cell_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                direction_reg <= cfg_data;
            end
            if (ctl.move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;

endmodule

`default_nettype wire

>>> rtl/core/mtf_controller.sv
// sequencer for load, two search steps and list rotation
// depends on mtf_pkg; drives mtf_datapath
`timescale 1ns / 1ps
`default_nettype none

module mtf_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mtf_pkg::mtf_stat_t stat,
    output mtf_pkg::mtf_ctl_t       ctl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_MOVE  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_SCAN;
            ST_SCAN:  state_next = ST_MERGE;
            ST_MERGE: state_next = ST_MOVE;
            ST_MOVE:  if (stat.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign ctl.load       = (state_reg == ST_IDLE) && in_valid;
    assign ctl.scan_group = (state_reg == ST_SCAN);
    assign ctl.scan_final = (state_reg == ST_MERGE);
    assign ctl.move       = (state_reg == ST_MOVE) && stat.out_free;

`ifndef SYNTHESIS
    a_load_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.scan_group)
        else $error("scan did not follow item load");

    a_scan_then_merge: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan_group |=> ctl.scan_final)
        else $error("merge did not follow group scan");

    a_move_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.move |=> !ctl.move && !ctl.scan_group)
        else $error("list moved twice for one item");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan_group || ctl.scan_final) |-> !ctl.load && in_stall)
        else $error("item taken while search in progress");
`endif

endmodule

`default_nettype wire

>>> rtl/core/move_to_front_codec_unit.sv
// top level of the byte-wide move-to-front codec
// depends on mtf_pkg, mtf_controller, mtf_datapath
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_byte, block_start
//   out      out_valid/ out_stall out_byte
//   cfg      cfg_valid/ cfg_ready cfg_data (direction, 0 encode, 1 decode)
//
// four steps per item: transfer, group compare, group merge, list rotate
// the two-level compare tree over the list cells sets the latency
// the rotate step waits while a previous result is stalled in the output register
// reset puts the list in identity order and selects encode
// block_start reloads identity order at the input transfer
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_codec_unit #(
    parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [mtf_pkg::SYM_W-1:0] in_byte,
    input  wire logic                      block_start,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [mtf_pkg::SYM_W-1:0]      out_byte
);

    mtf_pkg::mtf_ctl_t  ctl;
    mtf_pkg::mtf_stat_t stat;

    assign cfg_ready = 1'b1;

    mtf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    mtf_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .in_byte     (in_byte),
        .block_start (block_start),
        .out_stall   (out_stall),
        .ctl         (ctl),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_byte    (out_byte)
    );

endmodule

`default_nettype wire
